// ----- hw/rtl/pmd_pkg.sv -----
`timescale 1ns / 1ps

package pmd_pkg;

	// Field widths of the channels and registers.
	localparam int COEF_W = 32;
	localparam int ROW_W  = 2;
	localparam int POW_W  = 4;
	localparam int OPOW_W = 6;
	localparam int DIM_W  = 3;
	localparam int CIDX_W = 1;

	localparam int DEF_MAX_DEG = 8;
	localparam int DEF_MAX_DIM = 4;

	localparam logic [COEF_W-1:0] MOD_RESET = 32'd65521;
	localparam logic [DIM_W-1:0]  DIM_RESET = 3'd4;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [CIDX_W-1:0] REG_DIM     = 1'b1;

	// Widths of the address and length fields of one program operation.
	localparam int OA_W = 12;
	localparam int OL_W = 10;

	// Operation kinds of the expansion program.
	localparam logic [1:0] OP_NOP  = 2'd0;
	localparam logic [1:0] OP_ZERO = 2'd1;
	localparam logic [1:0] OP_MAC  = 2'd2;
	localparam logic [1:0] OP_END  = 2'd3;

	// Column pairs of the shared 2x2 minors, in minor order.
	localparam int PAIR_A [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_B [6] = '{1, 2, 3, 2, 3, 3};

	typedef struct packed {
		logic [1:0]      kind;
		logic [OA_W-1:0] dst;
		logic [OL_W-1:0] dlen;
		logic [OA_W-1:0] a;
		logic [OL_W-1:0] alen;
		logic [OA_W-1:0] b;
		logic [OL_W-1:0] blen;
		logic            b_one;
		logic            neg;
	} op_t;

	typedef struct packed {
		logic              start;
		logic              neg;
		logic [COEF_W-1:0] a;
		logic [COEF_W-1:0] b;
		logic [COEF_W-1:0] d;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [COEF_W-1:0] r;
	} mm_rsp_t;

	function automatic int pair_idx(input int a, input int b);
		int p;
		p = 5;
		if (a == 0 && b == 1) p = 0;
		else if (a == 0 && b == 2) p = 1;
		else if (a == 0 && b == 3) p = 2;
		else if (a == 1 && b == 2) p = 3;
		else if (a == 1 && b == 3) p = 4;
		return p;
	endfunction

	function automatic int ent(input int r, input int c, input int mdim, input int nc);
		return (r * mdim + c) * nc;
	endfunction

	function automatic op_t mk_mac(input int dst, input int dlen, input int a, input int alen,
		input int b, input int blen, input logic one, input logic neg);
		op_t op;
		op.kind  = OP_MAC;
		op.dst   = OA_W'(dst);
		op.dlen  = OL_W'(dlen);
		op.a     = OA_W'(a);
		op.alen  = OL_W'(alen);
		op.b     = OA_W'(b);
		op.blen  = OL_W'(blen);
		op.b_one = one;
		op.neg   = neg;
		return op;
	endfunction

	function automatic op_t mk_zero(input int dst, input int len);
		op_t op;
		op      = '0;
		op.kind = OP_ZERO;
		op.dst  = OA_W'(dst);
		op.dlen = OL_W'(len);
		return op;
	endfunction

	// One operation of the cofactor expansion for a given matrix size.
	function automatic op_t prog_op(input int deg, input int mdim, input logic [DIM_W-1:0] dim,
		input logic [5:0] pc);
		int nc, m2, p3, dl, mnb, par, dt, j, p, a, b, c, k, s, d;
		op_t op;
		nc  = deg + 1;
		m2  = 2 * deg + 1;
		p3  = 3 * deg + 1;
		dl  = mdim * deg + 1;
		mnb = mdim * mdim * nc;
		par = mnb + 6 * m2;
		dt  = par + p3;
		d   = int'(dim);
		j   = int'(pc);
		op      = '0;
		op.kind = OP_END;
		if (j == 0) begin
			op = mk_zero(mnb, 6 * m2 + p3 + dl);
		end else if (d == 1) begin
			if (j == 1) op = mk_mac(dt, dl, 0, nc, 0, 1, 1'b1, 1'b0);
		end else if (j <= 12) begin
			p = (j - 1) >> 1;
			a = PAIR_A[p];
			b = PAIR_B[p];
			if (b >= d) begin
				op.kind = OP_NOP;
			end else if (((j - 1) & 1) == 0) begin
				op = mk_mac(mnb + p * m2, m2, ent(0, a, mdim, nc), nc,
					ent(1, b, mdim, nc), nc, 1'b0, 1'b0);
			end else begin
				op = mk_mac(mnb + p * m2, m2, ent(0, b, mdim, nc), nc,
					ent(1, a, mdim, nc), nc, 1'b0, 1'b1);
			end
		end else if (d == 2) begin
			if (j == 13) op = mk_mac(dt, dl, mnb, m2, 0, 1, 1'b1, 1'b0);
		end else if (d == 3) begin
			if (j <= 15) begin
				k  = j - 13;
				a  = (k == 0) ? 1 : 0;
				b  = (k == 2) ? 1 : 2;
				op = mk_mac(dt, dl, ent(2, k, mdim, nc), nc, mnb + pair_idx(a, b) * m2, m2,
					1'b0, (k & 1) != 0);
			end
		end else begin
			if (j <= 32) begin
				k = (j >= 28) ? 3 : (j >= 23) ? 2 : (j >= 18) ? 1 : 0;
				s = j - 13 - 5 * k;
				a = (k == 0) ? 1 : 0;
				b = (k <= 1) ? 2 : 1;
				c = (k == 3) ? 2 : 3;
				case (s)
					0: op = mk_zero(par, p3);
					1: op = mk_mac(par, p3, ent(2, a, mdim, nc), nc,
						mnb + pair_idx(b, c) * m2, m2, 1'b0, 1'b0);
					2: op = mk_mac(par, p3, ent(2, b, mdim, nc), nc,
						mnb + pair_idx(a, c) * m2, m2, 1'b0, 1'b1);
					3: op = mk_mac(par, p3, ent(2, c, mdim, nc), nc,
						mnb + pair_idx(a, b) * m2, m2, 1'b0, 1'b0);
					default: op = mk_mac(dt, dl, ent(3, k, mdim, nc), nc, par, p3,
						1'b0, (k & 1) == 0);
				endcase
			end
		end
		return op;
	endfunction

endpackage

// ----- hw/rtl/pmd_load_if.sv -----
`timescale 1ns / 1ps

interface pmd_load_if;
	logic                         valid;
	logic                         ready;
	logic [pmd_pkg::ROW_W-1:0]    row;
	logic [pmd_pkg::ROW_W-1:0]    col;
	logic [pmd_pkg::POW_W-1:0]    power;
	logic [pmd_pkg::COEF_W-1:0]   coeff;
	logic                         last;

	modport source (output valid, row, col, power, coeff, last, input ready);
	modport sink (input valid, row, col, power, coeff, last, output ready);
endinterface

// ----- hw/rtl/pmd_result_if.sv -----
`timescale 1ns / 1ps

interface pmd_result_if;
	logic                         valid;
	logic                         ready;
	logic [pmd_pkg::OPOW_W-1:0]   out_power;
	logic [pmd_pkg::COEF_W-1:0]   out_coeff;
	logic                         out_last;

	modport source (output valid, out_power, out_coeff, out_last, input ready);
	modport sink (input valid, out_power, out_coeff, out_last, output ready);
endinterface

// ----- hw/rtl/pmd_cfg_if.sv -----
`timescale 1ns / 1ps

interface pmd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pmd_pkg::CIDX_W-1:0]   index;
	logic [pmd_pkg::COEF_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pmd_mulmod.sv -----
`timescale 1ns / 1ps

// Serial modular multiply-accumulate: r = (d +/- a*b) mod m, one bit of b per cycle.
// Operand a and d must already be below the modulus; b may be any value.
module pmd_mulmod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pmd_pkg::COEF_W-1:0]   modulus,
	input  pmd_pkg::mm_req_t             req,
	output pmd_pkg::mm_rsp_t             rsp
);

	localparam int W = pmd_pkg::COEF_W;
	localparam logic [5:0] STEPS = 6'(W);

	logic         busy_q;
	logic         done_q;
	logic [5:0]   cnt_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] d_q;
	logic         neg_q;
	logic [W-1:0] r_q;

	logic [W:0]   m;
	logic [W+1:0] m1;
	logic [W+1:0] m2;
	logic [W+1:0] t;
	logic [W-1:0] acc_n;
	logic [W+1:0] sum;
	logic [W-1:0] res;

	// A zero register selects arithmetic modulo two to the word width.
	assign m  = {(modulus == '0), modulus};
	assign m1 = {1'b0, m};
	assign m2 = {m, 1'b0};

	always_comb begin
		t = {1'b0, acc_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
		if (t >= m2) begin
			acc_n = W'(t - m2);
		end else if (t >= m1) begin
			acc_n = W'(t - m1);
		end else begin
			acc_n = W'(t);
		end
		if (neg_q) begin
			if (d_q >= acc_q) begin
				sum = {2'b00, d_q} - {2'b00, acc_q};
			end else begin
				sum = {2'b00, d_q} + m1 - {2'b00, acc_q};
			end
			res = W'(sum);
		end else begin
			sum = {2'b00, d_q} + {2'b00, acc_q};
			res = (sum >= m1) ? W'(sum - m1) : W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == STEPS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			d_q   <= req.d;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (cnt_q == STEPS) begin
				r_q <= res;
			end else begin
				acc_q <= acc_n;
				b_q   <= {b_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = r_q;

endmodule

// ----- hw/rtl/pmd_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer of the expansion: coefficient store, working stores and the program walker.
module pmd_ctrl #(
	parameter int MAX_DEG = pmd_pkg::DEF_MAX_DEG,
	parameter int MAX_DIM = pmd_pkg::DEF_MAX_DIM
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pmd_load_if.sink                     load,
	pmd_result_if.source                 result,
	input  logic [pmd_pkg::DIM_W-1:0]    dim_in_use,
	input  logic                         mod_is_one,
	output pmd_pkg::mm_req_t             mm_req,
	input  pmd_pkg::mm_rsp_t             mm_rsp
);

	localparam int W      = pmd_pkg::COEF_W;
	localparam int OL_W   = pmd_pkg::OL_W;
	localparam int NC     = MAX_DEG + 1;
	localparam int M2     = 2 * MAX_DEG + 1;
	localparam int P3     = 3 * MAX_DEG + 1;
	localparam int DL     = MAX_DIM * MAX_DEG + 1;
	localparam int MATSZ  = MAX_DIM * MAX_DIM * NC;
	localparam int DET_B  = MATSZ + 6 * M2 + P3;
	localparam int DEPTH  = DET_B + DL;
	localparam int AW     = $clog2(DEPTH);
	localparam int LW     = $clog2((P3 > DL) ? P3 + 1 : DL + 1);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_LOAD  = 4'd2;
	localparam logic [3:0] ST_RRD   = 4'd3;
	localparam logic [3:0] ST_RGO   = 4'd4;
	localparam logic [3:0] ST_RMUL  = 4'd5;
	localparam logic [3:0] ST_OP    = 4'd6;
	localparam logic [3:0] ST_ZERO  = 4'd7;
	localparam logic [3:0] ST_RA    = 4'd8;
	localparam logic [3:0] ST_RB    = 4'd9;
	localparam logic [3:0] ST_RD    = 4'd10;
	localparam logic [3:0] ST_GO    = 4'd11;
	localparam logic [3:0] ST_MUL   = 4'd12;
	localparam logic [3:0] ST_ORD   = 4'd13;
	localparam logic [3:0] ST_OCAP  = 4'd14;
	localparam logic [3:0] ST_OWAIT = 4'd15;

	logic [3:0]                   state_q;
	logic [5:0]                   pc_q;
	logic [LW-1:0]                i_q;
	logic [LW-1:0]                j_q;
	logic [LW-1:0]                k_q;
	logic [AW-1:0]                idx_q;
	logic [pmd_pkg::DIM_W-1:0]    dim_q;
	pmd_pkg::op_t                 op_q;
	logic [AW-1:0]                la_q;
	logic                         lok_q;
	logic                         llast_q;

	logic                         start_q;
	logic                         neg_q;
	logic [W-1:0]                 a_q;
	logic [W-1:0]                 b_q;
	logic [W-1:0]                 d_q;

	logic                         ov_q;
	logic [pmd_pkg::OPOW_W-1:0]   opow_q;
	logic [W-1:0]                 ocoef_q;
	logic                         olast_q;

	logic [W-1:0]                 mem [DEPTH];
	logic [W-1:0]                 rdata_q;

	logic [AW-1:0]                ra;
	logic                         we;
	logic [AW-1:0]                wa;
	logic [W-1:0]                 wd;
	pmd_pkg::op_t                 op_c;
	logic [pmd_pkg::DIM_W-1:0]    dim_c;
	logic [LW:0]                  ij;
	logic [LW:0]                  j1;
	logic [LW:0]                  i1;
	logic                         jmore;
	logic                         imore;
	logic [AW-1:0]                daddr;
	logic [LW-1:0]                klast;
	logic [W-1:0]                 one_red;
	logic                         lok_c;
	logic [AW-1:0]                la_c;

	assign op_c    = pmd_pkg::prog_op(MAX_DEG, MAX_DIM, dim_q, pc_q);
	assign dim_c   = (dim_in_use == '0) ? 3'd1 :
		(int'(dim_in_use) > MAX_DIM) ? 3'(MAX_DIM) : dim_in_use;
	assign ij      = {1'b0, i_q} + {1'b0, j_q};
	assign j1      = {1'b0, j_q} + 1'b1;
	assign i1      = {1'b0, i_q} + 1'b1;
	assign jmore   = (OL_W'(j1) < op_q.blen) && (OL_W'(ij) + 1'b1 < op_q.dlen);
	assign imore   = (OL_W'(i1) < op_q.alen) && (OL_W'(i1) < op_q.dlen);
	assign daddr   = AW'(op_q.dst) + AW'(ij);
	assign klast   = LW'(int'(dim_q) * MAX_DEG);
	assign one_red = {{(W-1){1'b0}}, ~mod_is_one};
	assign lok_c   = (int'(load.power) <= MAX_DEG) && (int'(load.row) < MAX_DIM) &&
		(int'(load.col) < MAX_DIM);
	assign la_c    = AW'((int'(load.row) * MAX_DIM + int'(load.col)) * NC + int'(load.power));

	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
				wa = idx_q;
			end
			ST_LOAD: begin
				we = mm_rsp.done && lok_q;
				wa = la_q;
				wd = mm_rsp.r;
			end
			ST_RRD: ra = idx_q;
			ST_RMUL: begin
				we = mm_rsp.done;
				wa = idx_q;
				wd = mm_rsp.r;
			end
			ST_ZERO: begin
				we = 1'b1;
				wa = AW'(op_q.dst) + idx_q;
			end
			ST_RA: ra = AW'(op_q.a) + AW'(i_q);
			ST_RB: ra = AW'(op_q.b) + AW'(j_q);
			ST_RD: ra = daddr;
			ST_MUL: begin
				we = mm_rsp.done;
				wa = daddr;
				wd = mm_rsp.r;
			end
			ST_ORD: ra = AW'(DET_B) + AW'(k_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			idx_q   <= '0;
			start_q <= 1'b0;
			ov_q    <= 1'b0;
			pc_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					if (idx_q == AW'(MATSZ - 1)) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (load.valid) begin
						start_q <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (mm_rsp.done) begin
						idx_q   <= '0;
						state_q <= llast_q ? ST_RRD : ST_IDLE;
					end
				end
				ST_RRD: state_q <= ST_RGO;
				ST_RGO: begin
					start_q <= 1'b1;
					state_q <= ST_RMUL;
				end
				ST_RMUL: begin
					if (mm_rsp.done) begin
						if (idx_q == AW'(MATSZ - 1)) begin
							pc_q    <= '0;
							state_q <= ST_OP;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RRD;
						end
					end
				end
				ST_OP: begin
					case (op_c.kind)
						pmd_pkg::OP_NOP: pc_q <= pc_q + 6'd1;
						pmd_pkg::OP_ZERO: begin
							idx_q   <= '0;
							state_q <= ST_ZERO;
						end
						pmd_pkg::OP_MAC: begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_RA;
						end
						default: begin
							k_q     <= '0;
							state_q <= ST_ORD;
						end
					endcase
				end
				ST_ZERO: begin
					if (OL_W'(idx_q) + 1'b1 == op_q.dlen) begin
						pc_q    <= pc_q + 6'd1;
						state_q <= ST_OP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RA: state_q <= ST_RB;
				ST_RB: state_q <= ST_RD;
				ST_RD: state_q <= ST_GO;
				ST_GO: begin
					start_q <= 1'b1;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mm_rsp.done) begin
						if (jmore) begin
							j_q     <= LW'(j1);
							state_q <= ST_RA;
						end else if (imore) begin
							i_q     <= LW'(i1);
							j_q     <= '0;
							state_q <= ST_RA;
						end else begin
							pc_q    <= pc_q + 6'd1;
							state_q <= ST_OP;
						end
					end
				end
				ST_ORD: state_q <= ST_OCAP;
				ST_OCAP: begin
					ov_q    <= 1'b1;
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (result.ready) begin
						ov_q <= 1'b0;
						if (olast_q) begin
							idx_q   <= '0;
							state_q <= ST_CLR;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	// Operands of the shared unit and the held payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				la_q    <= la_c;
				lok_q   <= lok_c;
				llast_q <= load.last;
				dim_q   <= dim_c;
				a_q     <= one_red;
				b_q     <= load.coeff;
				d_q     <= '0;
				neg_q   <= 1'b0;
			end
			ST_RGO: begin
				a_q   <= one_red;
				b_q   <= rdata_q;
				d_q   <= '0;
				neg_q <= 1'b0;
			end
			ST_OP: op_q <= op_c;
			ST_RB: a_q <= rdata_q;
			ST_RD: b_q <= op_q.b_one ? {{(W-1){1'b0}}, 1'b1} : rdata_q;
			ST_GO: begin
				d_q   <= rdata_q;
				neg_q <= op_q.neg;
			end
			ST_OCAP: begin
				ocoef_q <= rdata_q;
				opow_q  <= pmd_pkg::OPOW_W'(k_q);
				olast_q <= (k_q == klast);
			end
			default: ;
		endcase
	end

	assign load.ready       = (state_q == ST_IDLE);
	assign result.valid     = ov_q;
	assign result.out_power = opow_q;
	assign result.out_coeff = ocoef_q;
	assign result.out_last  = olast_q;

	assign mm_req.start = start_q;
	assign mm_req.neg   = neg_q;
	assign mm_req.a     = a_q;
	assign mm_req.b     = b_q;
	assign mm_req.d     = d_q;

`ifndef SYNTH
	// The shared unit only finishes while the sequencer waits on it.
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == ST_LOAD || state_q == ST_RMUL || state_q == ST_MUL))
		else $error("multiplier finished outside a wait state");

	// A result word is only offered from the output wait state.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (state_q == ST_OWAIT))
		else $error("result offered outside the output state");

	// Clearing the working stores never touches the coefficient store.
	a_zero_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ZERO) |-> (int'(wa) >= MATSZ))
		else $error("working clear hit the coefficient store");

	// A start is a single-cycle pulse.
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q)
		else $error("multiplier start held for two cycles");
`endif

endmodule

// ----- hw/rtl/poly_matrix_det_small.sv -----
`timescale 1ns / 1ps

// Determinant of a square matrix (size 1 to MAX_DIM, from the dim_in_use register) whose entries
// are polynomials of degree up to MAX_DEG with coefficients modulo the modulus register (zero
// means modulo 2^32). Each load word in range writes one coefficient, reduced on the way in, into a store
// that starts cleared; a word with last set also starts the computation, after which
// dim*MAX_DEG+1 result words come out from the lowest power up, zero leading terms included,
// and the coefficient store is cleared again. All arithmetic runs through one serial modular
// multiply-accumulate unit that retires one bit of its multiplier per cycle; a load word without
// last is taken only once the reduction of the previous word has finished. A word with last first
// re-reduces the whole coefficient store (one product per coefficient), then walks the cofactor
// expansion, reading both factors and the partial sum for each product term: some 3700 terms for
// a 4x4 matrix of degree 8. Each result word is read from the store, registered and then held
// until the sink takes it, and the closing clear wipes every stored coefficient. The same
// clearing pass runs after reset, so the load channel is not ready until it has finished.
// Configuration writes are taken at any time but should only be issued while the block is idle.
module poly_matrix_det_small #(
	parameter int MAX_DEG = pmd_pkg::DEF_MAX_DEG,
	parameter int MAX_DIM = pmd_pkg::DEF_MAX_DIM
) (
	input  logic          clk,
	input  logic          arst_n,
	pmd_cfg_if.sink       cfg,
	pmd_load_if.sink      load,
	pmd_result_if.source  result
);

	// Configuration registers.
	logic [pmd_pkg::COEF_W-1:0] modulus_q;
	logic [pmd_pkg::DIM_W-1:0]  dim_q;

	pmd_pkg::mm_req_t mm_req;
	pmd_pkg::mm_rsp_t mm_rsp;

	// The configuration channel never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= pmd_pkg::MOD_RESET;
			dim_q     <= pmd_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				pmd_pkg::REG_MODULUS: modulus_q <= cfg.data;
				pmd_pkg::REG_DIM:     dim_q     <= cfg.data[pmd_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// The shared arithmetic unit.
	pmd_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.req     (mm_req),
		.rsp     (mm_rsp)
	);

	// Sequencer, stores and the output register.
	pmd_ctrl #(
		.MAX_DEG (MAX_DEG),
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.result     (result),
		.dim_in_use (dim_q),
		.mod_is_one (modulus_q == 32'd1),
		.mm_req     (mm_req),
		.mm_rsp     (mm_rsp)
	);

endmodule

// ----- tb/pmd_tb_pkg.sv -----
`timescale 1ns / 1ps

package pmd_tb_pkg;

	// One determinant coefficient as it leaves the block.
	typedef struct packed {
		logic [pmd_pkg::OPOW_W-1:0] power;
		logic [pmd_pkg::COEF_W-1:0] coeff;
		logic                       last;
	} det_word_t;

	// A polynomial long enough for any product kept by the expansion.
	localparam int POLY_LEN = pmd_pkg::DEF_MAX_DIM * pmd_pkg::DEF_MAX_DEG + 1;
	typedef bit [pmd_pkg::COEF_W-1:0] poly_t [POLY_LEN];

endpackage

// ----- tb/pmd_det_checker.sv -----
`timescale 1ns / 1ps

module pmd_det_checker
	import pmd_pkg::*;
	import pmd_tb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	pmd_cfg_if     cfg,
	pmd_load_if    load,
	pmd_result_if  result,
	output int     errors,
	output int     pending
);

	localparam int DEG = DEF_MAX_DEG;
	localparam int NC  = DEG + 1;
	localparam int M2  = 2 * DEG + 1;
	localparam int P3  = 3 * DEG + 1;

	// Minor slot of each column pair.
	int pair_slot [4][4] = '{'{0, 0, 1, 2}, '{0, 0, 3, 4}, '{1, 3, 0, 5}, '{2, 4, 5, 0}};

	bit [COEF_W-1:0] modulus_reg;
	bit [DIM_W-1:0]  dim_reg;
	bit [COEF_W-1:0] coef_mem [16][NC];
	bit [63:0]       ring_mod;
	poly_t           minor_set [6];
	poly_t           cofactor3;
	poly_t           det_poly;
	det_word_t       det_words_q [$];

	function automatic poly_t poly_mac(poly_t acc, int acc_len, poly_t x, int x_len,
		poly_t y, int y_len, bit neg);
		bit [63:0] t;
		bit [63:0] d;
		for (int i = 0; i < x_len; i++)
			for (int j = 0; j < y_len && i + j < acc_len; j++) begin
				t = (64'(x[i]) * 64'(y[j])) % ring_mod;
				d = 64'(acc[i + j]);
				if (neg) d = (d + ring_mod - t) % ring_mod;
				else d = (d + t) % ring_mod;
				acc[i + j] = d[31:0];
			end
		return acc;
	endfunction

	function automatic poly_t entry_poly(int r, int c);
		poly_t p;
		p = '{default: '0};
		for (int i = 0; i < NC; i++) p[i] = coef_mem[r * 4 + c][i];
		return p;
	endfunction

	function automatic poly_t zero_poly();
		poly_t p;
		p = '{default: '0};
		return p;
	endfunction

	// Cofactor expansion over the first rows, sharing the 2x2 minors of rows 0 and 1.
	task automatic expand_det(int span);
		int a, b, c, n;
		int cols [3];
		for (int e = 0; e < 16; e++)
			for (int i = 0; i < NC; i++) coef_mem[e][i] = 32'(64'(coef_mem[e][i]) % ring_mod);
		det_poly = zero_poly();
		if (span == 1) begin
			det_poly = entry_poly(0, 0);
			return;
		end
		for (a = 0; a < span; a++)
			for (b = a + 1; b < span; b++) begin
				minor_set[pair_slot[a][b]] = poly_mac(zero_poly(), M2, entry_poly(0, a), NC,
					entry_poly(1, b), NC, 1'b0);
				minor_set[pair_slot[a][b]] = poly_mac(minor_set[pair_slot[a][b]], M2,
					entry_poly(0, b), NC, entry_poly(1, a), NC, 1'b1);
			end
		if (span == 2) begin
			det_poly = minor_set[0];
		end else if (span == 3) begin
			for (int k = 0; k < 3; k++) begin
				a = (k == 0) ? 1 : 0;
				b = (k == 2) ? 1 : 2;
				det_poly = poly_mac(det_poly, POLY_LEN, entry_poly(2, k), NC,
					minor_set[pair_slot[a][b]], M2, k[0]);
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				n = 0;
				for (int i = 0; i < 4; i++)
					if (i != k) begin
						cols[n] = i;
						n++;
					end
				a = cols[0];
				b = cols[1];
				c = cols[2];
				cofactor3 = poly_mac(zero_poly(), P3, entry_poly(2, a), NC,
					minor_set[pair_slot[b][c]], M2, 1'b0);
				cofactor3 = poly_mac(cofactor3, P3, entry_poly(2, b), NC,
					minor_set[pair_slot[a][c]], M2, 1'b1);
				cofactor3 = poly_mac(cofactor3, P3, entry_poly(2, c), NC,
					minor_set[pair_slot[a][b]], M2, 1'b0);
				det_poly = poly_mac(det_poly, POLY_LEN, entry_poly(3, k), NC,
					cofactor3, P3, !k[0]);
			end
		end
	endtask

	task automatic report(string what, longint unsigned want, longint unsigned got);
		$display("chk: mismatch in %s, expected %0d, got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int span, n;
		det_word_t want;
		if (!arst_n) begin
			modulus_reg = MOD_RESET;
			dim_reg     = DIM_RESET;
			for (int e = 0; e < 16; e++)
				for (int i = 0; i < NC; i++) coef_mem[e][i] = '0;
			det_words_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_MODULUS) modulus_reg = cfg.data;
				else if (cfg.index == REG_DIM) dim_reg = cfg.data[DIM_W-1:0];
			end
			if (load.valid && load.ready) begin
				ring_mod = (modulus_reg == 0) ? 64'h1_0000_0000 : 64'(modulus_reg);
				if (load.power <= DEG)
					coef_mem[load.row * 4 + load.col][load.power] =
						32'(64'(load.coeff) % ring_mod);
				if (load.last) begin
					span = (dim_reg == 0) ? 1 : (dim_reg > 4) ? 4 : int'(dim_reg);
					expand_det(span);
					n = span * DEG + 1;
					for (int k = 0; k < n; k++)
						det_words_q.push_back('{power: OPOW_W'(k), coeff: det_poly[k],
							last: (k == n - 1)});
					for (int e = 0; e < 16; e++)
						for (int i = 0; i < NC; i++) coef_mem[e][i] = '0;
				end
			end
			if (result.valid && result.ready) begin
				if (det_words_q.size() == 0) begin
					report("unexpected word", 0, result.out_power);
				end else begin
					want = det_words_q.pop_front();
					if (result.out_power !== want.power)
						report("out_power", want.power, result.out_power);
					if (result.out_coeff !== want.coeff)
						report("out_coeff", want.coeff, result.out_coeff);
					if (result.out_last !== want.last)
						report("out_last", want.last, result.out_last);
				end
			end
			pending = det_words_q.size();
		end
	end

endmodule

// ----- tb/poly_matrix_det_small_test.sv -----
`timescale 1ns / 1ps

module poly_matrix_det_small_test;
	import pmd_pkg::*;

	// A 4x4 expansion runs for a long stretch without any handshake, so the
	// watchdog limit must sit well clear of its length.
	localparam int IDLE_LIMIT  = 1000000;
	localparam int ITEM_TARGET = 480;

	logic clk;
	logic arst_n;
	int   chk_errors;
	int   chk_pending;
	int   idle_cycles;
	int   items_sent;
	int   stall_left;
	bit   calm;

	pmd_cfg_if    cfg_ch ();
	pmd_load_if   load_ch ();
	pmd_result_if res_ch ();

	poly_matrix_det_small u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.load   (load_ch),
		.result (res_ch)
	);

	pmd_det_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.load    (load_ch),
		.result  (res_ch),
		.errors  (chk_errors),
		.pending (chk_pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Gap lengths are mostly zero or short, with the odd long one. During a calm
	// phase neither side idles at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// The result side stalls at random; the ready line is recomputed once per edge.
	always @(posedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 9) < 3) stall_left = pick_gap();
		res_ch.ready <= (stall_left == 0);
		if (stall_left > 0) stall_left--;
	end

	// The watchdog counts edges at which no word moves on any channel.
	always @(posedge clk) begin
		if ((cfg_ch.valid && cfg_ch.ready) || (load_ch.valid && load_ch.ready)
			|| (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one coefficient word, after a random gap with valid low.
	task automatic load_word(int r, int c, int p, logic [COEF_W-1:0] v, bit fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			load_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		load_ch.valid <= 1'b1;
		load_ch.row   <= ROW_W'(r);
		load_ch.col   <= ROW_W'(c);
		load_ch.power <= POW_W'(p);
		load_ch.coeff <= v;
		load_ch.last  <= fin;
		@(posedge clk);
		while (!load_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Holds the load side back until every determinant word has been taken, then
	// leaves room for the clearing pass and any word still being absorbed.
	task automatic wait_drained();
		load_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// One matrix: mostly coefficients inside the active corner, with some noise
	// (out-of-range powers, entries outside the corner), closed by a last word.
	task automatic load_matrix(int span, int words);
		int r, c, p, sel;
		logic [COEF_W-1:0] v;
		for (int w = 0; w < words; w++) begin
			r = $urandom_range(0, span - 1);
			c = $urandom_range(0, span - 1);
			p = $urandom_range(0, DEF_MAX_DEG);
			if ($urandom_range(0, 99) < 15) begin
				if (span < 4 && $urandom_range(0, 1)) r = $urandom_range(span, 3);
				else p = $urandom_range(DEF_MAX_DEG + 1, 15);
			end
			sel = $urandom_range(0, 9);
			v = (sel == 0) ? '0 : (sel == 1) ? '1 : (sel == 2) ? COEF_W'($urandom_range(0, 20))
				: $urandom;
			load_word(r, c, p, v, w == words - 1);
		end
	endtask

	initial begin
		int span, dim_val, sets;
		logic [COEF_W-1:0] mod_val;
		arst_n        <= 1'b0;
		calm          = 1'b0;
		items_sent    = 0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= REG_MODULUS;
		cfg_ch.data  <= '0;
		load_ch.valid <= 1'b0;
		load_ch.row   <= '0;
		load_ch.col   <= '0;
		load_ch.power <= '0;
		load_ch.coeff <= '0;
		load_ch.last  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a full 4x4 with extreme coefficients, the top power, a
		// coefficient equal to the modulus and a write to a power beyond the limit.
		load_word(0, 0, 0, '1, 1'b0);
		load_word(0, 0, 8, 32'd65521, 1'b0);
		load_word(1, 1, 4, 32'd65520, 1'b0);
		load_word(2, 2, 8, 32'd1, 1'b0);
		load_word(3, 3, 0, 32'd1, 1'b0);
		load_word(3, 3, 8, 32'h12345, 1'b0);
		load_word(1, 2, 15, 32'd7, 1'b0);
		load_word(2, 1, 3, 32'd5, 1'b1);
		wait_drained();

		// Size zero acts as 1, modulus zero gives full 32-bit wrap-around; the last
		// word itself carries an ignored power but still starts the computation.
		write_reg(REG_DIM, 32'd0);
		write_reg(REG_MODULUS, 32'd0);
		load_word(0, 0, 8, '1, 1'b0);
		load_word(0, 0, 0, 32'h8000_0000, 1'b0);
		load_word(3, 0, 2, 32'd9, 1'b0);
		load_word(0, 0, 9, 32'd1, 1'b1);
		wait_drained();

		// Oversized size register and a modulus of one: every coefficient is zero.
		write_reg(REG_DIM, 32'd5);
		write_reg(REG_MODULUS, 32'd1);
		load_word(1, 3, 5, 32'hDEAD_BEEF, 1'b0);
		load_word(3, 1, 7, 32'd3, 1'b1);
		wait_drained();

		// Composite modulus, then changed part way through the loads so that the
		// stored words are reduced again when the computation starts.
		write_reg(REG_DIM, 32'd2);
		write_reg(REG_MODULUS, 32'd15);
		load_word(0, 0, 1, 32'd14, 1'b0);
		load_word(1, 1, 2, '1, 1'b0);
		load_word(0, 1, 0, 32'd6, 1'b0);
		wait_drained();
		write_reg(REG_MODULUS, 32'd7);
		load_word(1, 0, 8, 32'd3, 1'b1);
		wait_drained();

		// Random phases. Small sizes dominate since a 4x4 expansion is so slow; one
		// phase runs the full size.
		for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
			case (ph % 7)
				0, 4: span = 3;
				2, 6: span = 1;
				default: span = 2;
			endcase
			if (ph == 3) span = 4;
			case ($urandom_range(0, 5))
				0: mod_val = 32'hFFFF_FFFB;
				1: mod_val = 32'd2;
				2: mod_val = 32'd65521;
				3: mod_val = 32'd0;
				4: mod_val = '1;
				default: mod_val = $urandom | 32'd1;
			endcase
			dim_val = span;
			if (span == 1 && $urandom_range(0, 1)) dim_val = 0;
			if (span == 4 && $urandom_range(0, 1)) dim_val = 7;
			calm = ($urandom_range(0, 4) == 0);
			write_reg(REG_MODULUS, mod_val);
			write_reg(REG_DIM, COEF_W'({$urandom, 3'b000}) | COEF_W'(dim_val));
			sets = (span == 4) ? 1 : 2;
			for (int s = 0; s < sets; s++) begin
				case (span)
					1: load_matrix(1, $urandom_range(3, 8));
					2: load_matrix(2, $urandom_range(8, 20));
					3: load_matrix(3, $urandom_range(15, 35));
					default: load_matrix(4, $urandom_range(30, 50));
				endcase
			end
			wait_drained();
		end

		calm = 1'b0;
		if (chk_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
